FILE: rtl/core/rgv_pkg.sv
// Shared types and constants for the radial grid velocity recurrence unit.
// No dependencies.
package rgv_pkg;

  localparam int VW   = 48;          // value width, Q24.24
  localparam int DFW  = 17;          // donor fraction width, Q1.16
  localparam int SW   = 18;          // blend weight width, Q1.17
  localparam int RW   = VW + 18;     // blended density width
  localparam int DW   = 3 * VW + 18; // divisor width r^2 * rho_out
  localparam int NW   = 4 * VW + 18; // numerator width
  localparam int CW   = $clog2(VW + 1);

  localparam logic [DFW-1:0] DONOR_ONE = DFW'(65536);
  localparam logic [SW-1:0]  BLEND_ONE = SW'(131072);

  localparam logic [1:0] MODE_PRELOAD  = 2'd0;
  localparam logic [1:0] MODE_BOUNDARY = 2'd1;
  localparam logic [1:0] MODE_INTERIOR = 2'd2;
  localparam logic [1:0] MODE_SURFACE  = 2'd3;

  typedef struct packed {
    logic [1:0]           mode;
    logic [VW-1:0]        radius;
    logic signed [VW-1:0] u_old;
    logic signed [VW-1:0] u0_old;
    logic signed [VW-1:0] u_new;
    logic signed [VW-1:0] u0_seed;
    logic [VW-1:0]        density;
    logic [DFW-1:0]       donor_frac;
  } in_t;

  typedef struct packed {
    logic signed [VW-1:0] u0_new;
    logic                 div_error;
  } out_t;

  // classified item as queued for the back end
  typedef struct packed {
    logic [1:0]           mode;
    logic [VW-1:0]        radius;
    logic signed [VW-1:0] u_new;
    logic signed [VW-1:0] u0_seed;
    logic [VW-1:0]        density;
    logic [DFW-1:0]       donor;  // saturated to one
    logic                 fwd;    // outer cell upwind at this interface
  } cmd_t;

endpackage

FILE: rtl/core/rgv_front.sv
// Front end: accepts input transfers and classifies them into commands.
// Depends on rgv_pkg.
module rgv_front (
  input  logic          in_valid,
  input  rgv_pkg::in_t  in_data,
  output logic          in_stall,
  input  logic          q_full,
  output logic          q_push,
  output rgv_pkg::cmd_t q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_cmd.mode    = in_data.mode;
    q_cmd.radius  = in_data.radius;
    q_cmd.u_new   = in_data.u_new;
    q_cmd.u0_seed = in_data.u0_seed;
    q_cmd.density = in_data.density;
    q_cmd.donor   = (in_data.donor_frac > rgv_pkg::DONOR_ONE) ? rgv_pkg::DONOR_ONE
                                                              : in_data.donor_frac;
    q_cmd.fwd     = in_data.u_old < in_data.u0_old;
  end

endmodule

FILE: rtl/core/rgv_queue.sv
// Two-entry command queue between front and back end.
// Depends on rgv_pkg.
module rgv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rgv_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  input  logic          pop,
  output rgv_pkg::cmd_t pop_cmd
);

  rgv_pkg::cmd_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign pop_cmd = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/rgv_back.sv
// Back end: recurrence state, bit-serial shared multiplier, restoring divider
// and the output register. Depends on rgv_pkg.
module rgv_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  rgv_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output rgv_pkg::out_t out_data
);

  localparam int VW  = rgv_pkg::VW;
  localparam int RW  = rgv_pkg::RW;
  localparam int DW  = rgv_pkg::DW;
  localparam int NW  = rgv_pkg::NW;
  localparam int SW  = rgv_pkg::SW;
  localparam int DFW = rgv_pkg::DFW;
  localparam int CW  = rgv_pkg::CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_DCHK = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // multiply steps
  localparam logic [3:0] K_IN_CEN  = 4'd0;
  localparam logic [3:0] K_IN_UP   = 4'd1;
  localparam logic [3:0] K_OUT_CEN = 4'd2;
  localparam logic [3:0] K_OUT_UP  = 4'd3;
  localparam logic [3:0] K_R2      = 4'd4;
  localparam logic [3:0] K_DEN     = 4'd5;
  localparam logic [3:0] K_PR2     = 4'd6;
  localparam logic [3:0] K_MAG     = 4'd7;
  localparam logic [3:0] K_NUM     = 4'd8;

  localparam logic signed [VW-1:0] MAXB = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MINB = {1'b1, {(VW-1){1'b0}}};

  logic [2:0]           st_r;
  logic [3:0]           k_r;
  rgv_pkg::cmd_t        cmd_r;

  logic [VW-1:0]        prev_radius_r;
  logic signed [VW-1:0] prev_u_new_r, prev_u0_new_r;
  logic [VW-1:0]        inner_dens_r, mid_dens_r;
  logic [DFW-1:0]       inner_donor_r, mid_donor_r;

  logic [NW-1:0]        acc_r, mul_a_r, num_r;
  logic [RW-1:0]        mul_b_r, rho_in_r, rho_out_r;
  logic [DW-1:0]        den_r, rem_r;
  logic [VW-1:0]        q_r;
  logic [CW-1:0]        cnt_r;
  logic signed [VW-1:0] res_r;
  logic                 err_r;
  logic                 out_valid_r;
  rgv_pkg::out_t        out_data_r;

  // operand preparation
  logic                 neg;
  logic [VW:0]          cen_in, up_in, cen_out, up_out;
  logic [SW-1:0]        s_in, s_out;
  logic signed [VW:0]   diff;
  logic [VW-1:0]        mag;
  logic [DW:0]          trial;
  logic                 trial_ge;
  logic signed [VW+1:0] sum;

  assign neg    = prev_u_new_r < prev_u0_new_r;
  assign cen_in = (VW+1)'(inner_dens_r) + (VW+1)'(mid_dens_r);
  assign up_in  = {(neg ? mid_dens_r : inner_dens_r), 1'b0};
  assign s_in   = SW'(inner_donor_r) + SW'(mid_donor_r);
  assign diff   = (VW+1)'(prev_u_new_r) - (VW+1)'(prev_u0_new_r);
  assign mag    = neg ? VW'(-diff) : VW'(diff);

  always_comb begin
    if (cmd_r.mode == rgv_pkg::MODE_SURFACE) begin
      cen_out = (VW+1)'(mid_dens_r);
      up_out  = cmd_r.fwd ? '0 : {mid_dens_r, 1'b0};
      s_out   = {mid_donor_r, 1'b0};
    end else begin
      cen_out = (VW+1)'(mid_dens_r) + (VW+1)'(cmd_r.density);
      up_out  = {(cmd_r.fwd ? cmd_r.density : mid_dens_r), 1'b0};
      s_out   = SW'(mid_donor_r) + SW'(cmd_r.donor);
    end
  end

  assign trial    = {rem_r, num_r[VW-1]};
  assign trial_ge = trial >= (DW+1)'(den_r);
  assign sum      = neg ? (VW+2)'(cmd_r.u_new) - $signed((VW+2)'(q_r))
                        : (VW+2)'(cmd_r.u_new) + $signed((VW+2)'(q_r));

  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      out_valid_r   <= 1'b0;
      prev_radius_r <= '0;
      prev_u_new_r  <= '0;
      prev_u0_new_r <= '0;
      inner_dens_r  <= '0;
      mid_dens_r    <= '0;
      inner_donor_r <= '0;
      mid_donor_r   <= '0;
    end else begin
      // completion below reloads the register in the same cycle
      if (out_valid_r && !out_stall &&
          !(st_r == S_DONE && cmd_r.mode != rgv_pkg::MODE_PRELOAD))
        out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            k_r   <= K_IN_CEN;
            err_r <= 1'b0;
            res_r <= q_cmd.u0_seed;
            if (q_cmd.mode == rgv_pkg::MODE_PRELOAD || q_cmd.mode == rgv_pkg::MODE_BOUNDARY)
              st_r <= S_DONE;
            else
              st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          st_r <= S_RUN;
          case (k_r)
            K_IN_CEN: begin
              acc_r <= '0; mul_a_r <= NW'(cen_in); mul_b_r <= RW'(rgv_pkg::BLEND_ONE - s_in);
            end
            K_IN_UP: begin
              mul_a_r <= NW'(up_in); mul_b_r <= RW'(s_in);
            end
            K_OUT_CEN: begin
              acc_r <= '0; mul_a_r <= NW'(cen_out); mul_b_r <= RW'(rgv_pkg::BLEND_ONE - s_out);
            end
            K_OUT_UP: begin
              mul_a_r <= NW'(up_out); mul_b_r <= RW'(s_out);
            end
            K_R2: begin
              acc_r <= '0; mul_a_r <= NW'(cmd_r.radius); mul_b_r <= RW'(cmd_r.radius);
            end
            K_DEN: begin
              acc_r <= '0; mul_a_r <= NW'(den_r); mul_b_r <= rho_out_r;
            end
            K_PR2: begin
              acc_r <= '0; mul_a_r <= NW'(prev_radius_r); mul_b_r <= RW'(prev_radius_r);
            end
            K_MAG: begin
              acc_r <= '0; mul_a_r <= num_r; mul_b_r <= RW'(mag);
            end
            default: begin
              acc_r <= '0; mul_a_r <= num_r; mul_b_r <= rho_in_r;
            end
          endcase
        end
        S_RUN: begin
          if (mul_b_r == '0) begin
            k_r  <= k_r + 4'd1;
            st_r <= S_LOAD;
            case (k_r)
              K_IN_UP:  rho_in_r <= acc_r[RW-1:0];
              K_OUT_UP: begin
                rho_out_r <= acc_r[RW-1:0];
                if (cmd_r.radius == '0 || acc_r == '0) begin
                  res_r <= cmd_r.u_new;
                  err_r <= 1'b1;
                  st_r  <= S_DONE;
                end
              end
              K_R2, K_DEN: den_r <= acc_r[DW-1:0];
              K_PR2, K_MAG: num_r <= acc_r;
              K_NUM: begin
                num_r <= acc_r;
                st_r  <= S_DCHK;
              end
              default: ;
            endcase
          end else begin
            if (mul_b_r[0]) acc_r <= acc_r + mul_a_r;
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
          end
        end
        S_DCHK: begin
          // quotient fits VW bits only if the high part of num is below den
          if (num_r[NW-1:VW] >= den_r) begin
            res_r <= neg ? MINB : MAXB;
            st_r  <= S_DONE;
          end else begin
            rem_r <= num_r[NW-1:VW];
            cnt_r <= '0;
            st_r  <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= trial_ge ? DW'(trial - (DW+1)'(den_r)) : DW'(trial);
          q_r   <= {q_r[VW-2:0], trial_ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(VW - 1)) st_r <= S_FIN;
        end
        S_FIN: begin
          if (sum > (VW+2)'(MAXB))      res_r <= MAXB;
          else if (sum < (VW+2)'(MINB)) res_r <= MINB;
          else                          res_r <= VW'(sum);
          st_r <= S_DONE;
        end
        S_DONE: begin
          if (cmd_r.mode == rgv_pkg::MODE_PRELOAD || !out_valid_r || !out_stall) begin
            st_r <= S_IDLE;
            if (cmd_r.mode != rgv_pkg::MODE_SURFACE) begin
              inner_dens_r  <= mid_dens_r;
              inner_donor_r <= mid_donor_r;
              mid_dens_r    <= cmd_r.density;
              mid_donor_r   <= cmd_r.donor;
            end
            if (cmd_r.mode != rgv_pkg::MODE_PRELOAD) begin
              prev_radius_r        <= cmd_r.radius;
              prev_u_new_r         <= cmd_r.u_new;
              prev_u0_new_r        <= res_r;
              out_valid_r          <= 1'b1;
              out_data_r.u0_new    <= res_r;
              out_data_r.div_error <= err_r;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RUN && mul_b_r == '0) |=> (st_r != S_RUN))
    else $error("multiplier kept running after last bit");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_DONE))
    else $error("result loaded outside completion");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r != S_IDLE))
    else $error("command popped but sequencer stayed idle");

endmodule

FILE: rtl/core/radial_grid_velocity_recurrence_unit.sv
// Top level of the radial grid velocity recurrence unit.
// Depends on rgv_pkg, rgv_front, rgv_queue, rgv_back.
//
// Interfaces are fed from the inside out, one transfer per interface. A preload
// transfer (mode 0) shifts a cell into the two-cell window and gives no result;
// boundary (mode 1) returns the seed; interior (mode 2) and surface (mode 3)
// run the recurrence u0 = (u_new - u0_new prev) * (r_prev/r)^2 * rho_in/rho_out
// + u_new with exact wide arithmetic, truncating the quotient toward zero and
// saturating to 48 bits. A zero radius or zero outer density returns u_new
// with div_error set. Preload and boundary items go from the idle state straight
// to completion in the back end. Interior and surface items are bound by one
// shared bit-serial multiplier (one multiplier bit per cycle, nine products
// whose run lengths follow the significant bits of the weights, radii, velocity
// difference and densities) followed by a 48-step restoring divider. A
// two-entry command queue sits between the front end and the sequencer so
// input transfers keep landing while the back end works, and the output
// register holds a finished result until it is taken.
module radial_grid_velocity_recurrence_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rgv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rgv_pkg::out_t out_data
);

  logic          q_full, q_push, q_valid, q_pop;
  rgv_pkg::cmd_t push_cmd, pop_cmd;

  rgv_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rgv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd)
  );

  rgv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/radial_grid_velocity_recurrence_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for radial_grid_velocity_recurrence_unit.
// Depends on rgv_pkg; predicts every result with an exact wide-integer model.
module radial_grid_velocity_recurrence_unit_tb;

  localparam int  VW           = rgv_pkg::VW;
  localparam int  DFW          = rgv_pkg::DFW;
  localparam int  SW           = rgv_pkg::SW;
  localparam int  LIMIT_CYCLES = 1500000;
  localparam int  DRAIN_CYCLES = 1200;  // extra drain time after the last expected result
  localparam int  HOLD_CYCLES  = 3000;  // long receiver hold-off
  localparam int  BW           = 256;   // wide enough for r_prev^2 * mag * rho_in

  typedef logic [BW-1:0] wide_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  rgv_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rgv_pkg::out_t out_data;

  radial_grid_velocity_recurrence_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state: previous interface and the two-cell density window
  logic [VW-1:0]        prv_radius;
  logic signed [VW-1:0] prv_u_new, prv_u0_new;
  logic [VW-1:0]        inner_dens, mid_dens;
  logic [DFW-1:0]       inner_donor, mid_donor;

  rgv_pkg::out_t expected_q[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   hold_request = 0;

  // donor-cell blend: (1 - s) * (da + db) + s * 2 * dup, s in Q1.17
  function automatic wide_t donor_blend(logic [VW-1:0] da, logic [VW-1:0] db,
                                        logic [VW-1:0] dup, logic [SW-1:0] s);
    wide_t w_s;
    w_s = wide_t'(s);
    return (wide_t'(rgv_pkg::BLEND_ONE) - w_s) * (wide_t'(da) + wide_t'(db))
           + w_s * (wide_t'(dup) << 1);
  endfunction

  // Advances the predictor by one accepted item; returns 1 if it yields a result.
  function automatic bit predict_velocity(rgv_pkg::in_t x, output rgv_pkg::out_t r);
    logic [DFW-1:0] df;
    bit             back, fwd, neg;
    wide_t          rho_in, rho_out, den, num, q;
    logic [63:0]    mag;
    longint         sum, maxv, minv;
    logic [VW-1:0]  res;
    logic           err;
    df   = (x.donor_frac > rgv_pkg::DONOR_ONE) ? rgv_pkg::DONOR_ONE : x.donor_frac;
    maxv = (64'sd1 <<< (VW - 1)) - 1;
    minv = -(64'sd1 <<< (VW - 1));
    err  = 1'b0;
    r    = '0;
    if (x.mode == rgv_pkg::MODE_PRELOAD) begin
      inner_dens  = mid_dens;
      inner_donor = mid_donor;
      mid_dens    = x.density;
      mid_donor   = df;
      return 0;
    end
    if (x.mode == rgv_pkg::MODE_BOUNDARY) begin
      res = x.u0_seed;
    end else begin
      back   = prv_u_new < prv_u0_new;
      fwd    = x.u_old < x.u0_old;
      rho_in = donor_blend(inner_dens, mid_dens, back ? mid_dens : inner_dens,
                           SW'(inner_donor) + SW'(mid_donor));
      if (x.mode == rgv_pkg::MODE_INTERIOR)
        rho_out = donor_blend(mid_dens, x.density, fwd ? x.density : mid_dens,
                              SW'(mid_donor) + SW'(df));
      else
        rho_out = donor_blend(mid_dens, '0, fwd ? '0 : mid_dens, SW'(mid_donor) << 1);
      den = wide_t'(x.radius) * wide_t'(x.radius) * rho_out;
      if (den == '0) begin
        err = 1'b1;
        res = x.u_new;
      end else begin
        neg = back;
        mag = neg ? 64'(longint'(prv_u0_new) - longint'(prv_u_new))
                  : 64'(longint'(prv_u_new) - longint'(prv_u0_new));
        num = wide_t'(mag) * wide_t'(prv_radius) * wide_t'(prv_radius) * rho_in;
        q   = num / den;
        if (q >= (wide_t'(1) << VW)) begin
          res = neg ? VW'(minv) : VW'(maxv);
        end else begin
          sum = neg ? longint'(x.u_new) - longint'(q[63:0])
                    : longint'(x.u_new) + longint'(q[63:0]);
          if (sum > maxv) sum = maxv;
          if (sum < minv) sum = minv;
          res = VW'(sum);
        end
      end
    end
    prv_radius = x.radius;
    prv_u_new  = x.u_new;
    prv_u0_new = res;
    if (x.mode != rgv_pkg::MODE_SURFACE) begin
      inner_dens  = mid_dens;
      inner_donor = mid_donor;
      mid_dens    = x.density;
      mid_donor   = df;
    end
    r.u0_new    = res;
    r.div_error = err;
    return 1;
  endfunction

  // One transfer on the input channel, followed by an optional idle gap.
  task automatic send_interface(rgv_pkg::in_t x, int gap);
    rgv_pkg::out_t r;
    in_data  <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);  // pre-edge values decide the transfer
    if (predict_velocity(x, r)) expected_q.push_back(r);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender bursts: gap only at the end of a burst
  int burst_left = 0;
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
  endfunction

  function automatic rgv_pkg::in_t mk(logic [1:0] m, logic [VW-1:0] rad,
                                      logic [VW-1:0] uo, logic [VW-1:0] u0o,
                                      logic [VW-1:0] un, logic [VW-1:0] sd,
                                      logic [VW-1:0] dn, logic [DFW-1:0] df);
    rgv_pkg::in_t x;
    x.mode = m; x.radius = rad; x.u_old = uo; x.u0_old = u0o;
    x.u_new = un; x.u0_seed = sd; x.density = dn; x.donor_frac = df;
    return x;
  endfunction

  function automatic logic [VW-1:0] any48();
    return VW'({$urandom, $urandom});
  endfunction

  // velocity of modest size, either sign, Q24.24
  function automatic logic [VW-1:0] vel();
    longint v;
    v = longint'($urandom_range(0, 32'h0800_0000));
    if ($urandom_range(0, 1)) v = -v;
    if ($urandom_range(0, 15) == 0) v = longint'(signed'(any48()));
    return VW'(v);
  endfunction

  function automatic logic [VW-1:0] dens();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return any48();
      default: return VW'($urandom_range(32'h0010_0000, 32'h4000_0000));
    endcase
  endfunction

  function automatic logic [DFW-1:0] donor();
    case ($urandom_range(0, 9))
      0:       return DFW'($urandom_range(65537, 131071));  // saturates to one
      1:       return rgv_pkg::DONOR_ONE;
      2:       return '0;
      default: return DFW'($urandom_range(0, 65536));
    endcase
  endfunction

  // Edges of every field, each mode, zero divisor, saturation, oversized donor.
  task automatic test_directed();
    logic [VW-1:0] mx, mn, one;
    mx  = {1'b0, {(VW-1){1'b1}}};
    mn  = {1'b1, {(VW-1){1'b0}}};
    one = VW'(1) << 24;
    send_interface(mk(rgv_pkg::MODE_INTERIOR, one, '0, '0, one, '0, one, '0), 0);  // empty window
    send_interface(mk(rgv_pkg::MODE_PRELOAD, '1, mx, mn, mx, mn, '1, '1), 0);
    send_interface(mk(rgv_pkg::MODE_PRELOAD, '0, mn, mx, mn, mx, one, rgv_pkg::DONOR_ONE), 0);
    send_interface(mk(rgv_pkg::MODE_BOUNDARY, one, '0, '0, mn, mx, one * 2, '0), 0);
    send_interface(mk(rgv_pkg::MODE_INTERIOR, '0, '0, '0, one, '0, one, 17'd100), 0);  // r = 0
    send_interface(mk(rgv_pkg::MODE_INTERIOR, one, mn, mx, mx, '0, '1, '1), 3);
    send_interface(mk(rgv_pkg::MODE_INTERIOR, '1, mx, mn, mn, '0, '0, '0), 0);
    send_interface(mk(rgv_pkg::MODE_PRELOAD, '0, '0, '0, '0, '0, '1, 17'h1FFFF), 0);
    send_interface(mk(rgv_pkg::MODE_PRELOAD, '0, '0, '0, '0, '0, '1, rgv_pkg::DONOR_ONE), 0);
    send_interface(mk(rgv_pkg::MODE_BOUNDARY, '1, '0, '0, mx, mn, '1, rgv_pkg::DONOR_ONE), 0);
    send_interface(mk(rgv_pkg::MODE_INTERIOR, VW'(1), '0, '0, '0, '0, '1, '0), 0);  // high
    send_interface(mk(rgv_pkg::MODE_BOUNDARY, '1, '0, '0, mn, mx, '1, '0), 0);
    send_interface(mk(rgv_pkg::MODE_INTERIOR, VW'(1), '0, '0, mx, '0, '1, '0), 0);  // low
    send_interface(mk(rgv_pkg::MODE_INTERIOR, one * 2, mx, '0, one, '0, one, 17'd30000), 0);
    send_interface(mk(rgv_pkg::MODE_SURFACE, one * 3, mn, '0, -one, '0, '0, '0), 0);  // outer upwind
    send_interface(mk(rgv_pkg::MODE_SURFACE, one * 3, '0, '0, one, '0, '0, '0), 0);
    send_interface(mk(rgv_pkg::MODE_PRELOAD, '0, '0, '0, '0, '0, '0, '0), 0);
    send_interface(mk(rgv_pkg::MODE_PRELOAD, '0, '0, '0, '0, '0, '0, '0), 0);
    send_interface(mk(rgv_pkg::MODE_SURFACE, one, '0, '0, one, '0, '0, '0), 0);  // zero rho_out
    send_interface(mk(rgv_pkg::MODE_INTERIOR, one, '0, '0, mn, '0, '0, '0), 4);
  endtask

  // Well-formed star: two preloads, boundary, interior walk, optional surface.
  task automatic run_walk(int interiors);
    logic [VW-1:0] r;
    r = VW'($urandom_range(32'h0010_0000, 32'h0400_0000));
    send_interface(mk(rgv_pkg::MODE_PRELOAD, any48(), vel(), vel(), vel(), vel(), dens(),
                      donor()), next_gap());
    send_interface(mk(rgv_pkg::MODE_PRELOAD, any48(), vel(), vel(), vel(), vel(), dens(),
                      donor()), next_gap());
    send_interface(mk(rgv_pkg::MODE_BOUNDARY, r, vel(), vel(), vel(), vel(), dens(), donor()),
                   next_gap());
    repeat (interiors) begin
      r = ($urandom_range(0, 30) == 0) ? '0 : r + VW'($urandom_range(1, 32'h0200_0000));
      send_interface(mk(rgv_pkg::MODE_INTERIOR, r, vel(), vel(), vel(), vel(), dens(),
                        donor()), next_gap());
    end
    if ($urandom_range(0, 3) != 0)
      send_interface(mk(rgv_pkg::MODE_SURFACE, r + VW'($urandom_range(1, 32'h0100_0000)),
                        vel(), vel(), vel(), vel(), any48(), donor()), next_gap());
  endtask

  task automatic test_walks(int count);
    repeat (count) run_walk($urandom_range(2, 12));
  endtask

  // Arbitrary modes and full-range fields.
  task automatic test_noise(int count);
    repeat (count)
      send_interface(mk(2'($urandom_range(0, 3)), any48(), any48(), any48(), any48(),
                        any48(), any48(), DFW'($urandom)), next_gap());
  endtask

  // Receiver holds off while the sender keeps offering back to back.
  task automatic test_backpressure();
    hold_request = 1;
    burst_left = 40;
    run_walk(30);
    hold_request = 0;
  endtask

  // receiver: random stall pattern, quiet stretches, and the long hold-off
  initial begin
    int phase;
    int hold_done;
    hold_done = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
        out_stall <= 1'b0;
      end else if ((phase / 500) % 3 == 2) begin
        out_stall <= 1'b0;  // no-stall stretch
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // result checker: oldest expectation against each transfer out
  always @(posedge clk) begin
    rgv_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result u0_new=%h div_error=%b",
                 $time, out_data.u0_new, out_data.div_error);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.u0_new !== e.u0_new) begin
          $display("%0t: u0_new expected %h actual %h", $time, e.u0_new, out_data.u0_new);
          fail_count++;
        end
        if (out_data.div_error !== e.div_error) begin
          $display("%0t: div_error expected %b actual %b",
                   $time, e.div_error, out_data.div_error);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    prv_radius = '0; prv_u_new = '0; prv_u0_new = '0;
    inner_dens = '0; mid_dens = '0; inner_donor = '0; mid_donor = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_walks(45);
    test_backpressure();
    test_noise(60);
    test_walks(10);
    in_valid <= 1'b0;  // last item was just taken; do not offer it again
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rgv_pkg.sv
rtl/core/rgv_front.sv
rtl/core/rgv_queue.sv
rtl/core/rgv_back.sv
rtl/core/radial_grid_velocity_recurrence_unit.sv
tb/radial_grid_velocity_recurrence_unit_tb.sv
